@@ src/pwc_pkg.sv @@
package pwc_pkg;

    localparam int COORD_BITS    = 16;
    localparam int MAX_VERTS_DEF = 60;
    localparam int LIST_DEPTH    = 64;
    localparam int LIST_AW       = $clog2(LIST_DEPTH);
    localparam int LIST_CW       = LIST_AW + 1;
    localparam int NUM_EDGES     = 4;
    localparam int EDGE_BITS     = $clog2(NUM_EDGES);
    localparam int CFG_IDX_BITS  = 3;
    localparam int MUL_BITS      = COORD_BITS + 1;
    localparam int L_BITS        = 2 * COORD_BITS + 2;
    localparam int ACC_BITS      = 3 * COORD_BITS + 4;
    localparam int DSH_PAD       = ACC_BITS - L_BITS - COORD_BITS;
    localparam int UPC_BITS      = 5;

    localparam logic [CFG_IDX_BITS-1:0] CFG_CORNER0_X = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CORNER0_Y = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CORNER1_X = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CORNER1_Y = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CORNER2_X = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CORNER2_Y = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CORNER3_X = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CORNER3_Y = 3'd7;

    localparam logic [UPC_BITS-1:0] UPC_INSIDE = 5'd0;
    localparam logic [UPC_BITS-1:0] UPC_ISECT  = 5'd3;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
    } vertex_t;

    typedef struct packed {
        coord_t vert_x;
        coord_t vert_y;
        logic   final_vertex;
    } vert_in_t;

    typedef struct packed {
        coord_t out_x;
        coord_t out_y;
        logic   end_of_list;
        logic   empty_result;
        logic   overflowed;
    } clip_out_t;

    typedef enum logic [1:0] {
        ALU_CLR,
        ALU_MUL,
        ALU_ABS,
        ALU_DIV
    } alu_op_t;

    typedef enum logic [3:0] {
        M_NONE,
        M_PXA,
        M_PYA,
        M_AX,
        M_AY,
        M_SX,
        M_SY,
        M_DX1,
        M_DY1,
        M_L1,
        M_L2,
        M_DSH
    } mc_sel_t;

    typedef enum logic [3:0] {
        R_NONE,
        R_BYA,
        R_BXA,
        R_BY,
        R_BX,
        R_PY,
        R_PX,
        R_DY2,
        R_DX2,
        R_DX1,
        R_DY1
    } mp_sel_t;

    typedef enum logic [3:0] {
        ACT_NONE,
        ACT_INSIDE,
        ACT_L1,
        ACT_L2,
        ACT_DEN,
        ACT_DABS,
        ACT_NSIGN,
        ACT_RX,
        ACT_RY
    } act_t;

    typedef struct packed {
        alu_op_t op;
        logic    neg;
        mc_sel_t mc;
        mp_sel_t mp;
        act_t    act;
        logic    last;
    } uop_t;

    typedef struct packed {
        logic    go;
        alu_op_t op;
        logic    neg;
    } alu_cmd_t;

    typedef enum logic [1:0] {
        PH_S,
        PH_P,
        PH_X
    } phase_t;

    typedef enum logic [3:0] {
        S_LOAD,
        S_PASS_INIT,
        S_RD_WAIT,
        S_ISSUE,
        S_WAIT,
        S_AFTER,
        S_WR_ISECT,
        S_WR_PT,
        S_ADV,
        S_PASS_END,
        S_EMIT_RD,
        S_EMIT_LD,
        S_EMIT_HOLD
    } state_t;

    function automatic uop_t mk_uop(input alu_op_t op, input logic neg, input mc_sel_t mc,
                                    input mp_sel_t mp, input act_t act, input logic last);
        uop_t u;
        u.op   = op;
        u.neg  = neg;
        u.mc   = mc;
        u.mp   = mp;
        u.act  = act;
        u.last = last;
        return u;
    endfunction

    // inside test program, then intersection program
    function automatic uop_t uop_at(input logic [UPC_BITS-1:0] idx);
        uop_t u;
        u = mk_uop(ALU_CLR, 1'b0, M_NONE, R_NONE, ACT_NONE, 1'b0);
        case (idx)
            5'd0:  u = mk_uop(ALU_CLR, 1'b0, M_NONE, R_NONE, ACT_NONE,   1'b0);
            5'd1:  u = mk_uop(ALU_MUL, 1'b0, M_PXA,  R_BYA,  ACT_NONE,   1'b0);
            5'd2:  u = mk_uop(ALU_MUL, 1'b1, M_PYA,  R_BXA,  ACT_INSIDE, 1'b1);
            5'd3:  u = mk_uop(ALU_CLR, 1'b0, M_NONE, R_NONE, ACT_NONE,   1'b0);
            5'd4:  u = mk_uop(ALU_MUL, 1'b0, M_AX,   R_BY,   ACT_NONE,   1'b0);
            5'd5:  u = mk_uop(ALU_MUL, 1'b1, M_AY,   R_BX,   ACT_L1,     1'b0);
            5'd6:  u = mk_uop(ALU_CLR, 1'b0, M_NONE, R_NONE, ACT_NONE,   1'b0);
            5'd7:  u = mk_uop(ALU_MUL, 1'b0, M_SX,   R_PY,   ACT_NONE,   1'b0);
            5'd8:  u = mk_uop(ALU_MUL, 1'b1, M_SY,   R_PX,   ACT_L2,     1'b0);
            5'd9:  u = mk_uop(ALU_CLR, 1'b0, M_NONE, R_NONE, ACT_NONE,   1'b0);
            5'd10: u = mk_uop(ALU_MUL, 1'b0, M_DX1,  R_DY2,  ACT_NONE,   1'b0);
            5'd11: u = mk_uop(ALU_MUL, 1'b1, M_DY1,  R_DX2,  ACT_DEN,    1'b0);
            5'd12: u = mk_uop(ALU_ABS, 1'b0, M_NONE, R_NONE, ACT_DABS,   1'b0);
            5'd13: u = mk_uop(ALU_CLR, 1'b0, M_NONE, R_NONE, ACT_NONE,   1'b0);
            5'd14: u = mk_uop(ALU_MUL, 1'b0, M_L1,   R_DX2,  ACT_NONE,   1'b0);
            5'd15: u = mk_uop(ALU_MUL, 1'b1, M_L2,   R_DX1,  ACT_NSIGN,  1'b0);
            5'd16: u = mk_uop(ALU_ABS, 1'b0, M_NONE, R_NONE, ACT_NONE,   1'b0);
            5'd17: u = mk_uop(ALU_DIV, 1'b0, M_DSH,  R_NONE, ACT_RX,     1'b0);
            5'd18: u = mk_uop(ALU_CLR, 1'b0, M_NONE, R_NONE, ACT_NONE,   1'b0);
            5'd19: u = mk_uop(ALU_MUL, 1'b0, M_L1,   R_DY2,  ACT_NONE,   1'b0);
            5'd20: u = mk_uop(ALU_MUL, 1'b1, M_L2,   R_DY1,  ACT_NSIGN,  1'b0);
            5'd21: u = mk_uop(ALU_ABS, 1'b0, M_NONE, R_NONE, ACT_NONE,   1'b0);
            5'd22: u = mk_uop(ALU_DIV, 1'b0, M_DSH,  R_NONE, ACT_RY,     1'b1);
            default: u = mk_uop(ALU_CLR, 1'b0, M_NONE, R_NONE, ACT_NONE, 1'b1);
        endcase
        return u;
    endfunction

endpackage

@@ src/pwc_vbuf.sv @@
module pwc_vbuf
    import pwc_pkg::*;
(
    input  logic                 clk,
    input  logic                 we,
    input  logic [LIST_AW:0]     waddr,
    input  vertex_t              wdata,
    input  logic [LIST_AW:0]     raddr,
    output vertex_t              rdata
);

    // two ping-pong lists, bank select in the top address bit
    vertex_t mem [2*LIST_DEPTH];
    vertex_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ src/pwc_alu.sv @@
module pwc_alu
    import pwc_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  alu_cmd_t                   cmd,
    input  logic signed [ACC_BITS-1:0] mcand,
    input  logic signed [MUL_BITS-1:0] mplier,
    output logic                       busy,
    output logic signed [ACC_BITS-1:0] acc,
    output logic [MUL_BITS-1:0]        quot
);

    localparam int CNT_W = $clog2(MUL_BITS);

    logic [ACC_BITS-1:0] acc_reg, acc_next;
    logic [ACC_BITS-1:0] mc_reg, mc_next;
    logic [ACC_BITS-1:0] add_a, add_b, sum;
    logic                add_sub;
    logic [MUL_BITS-1:0] mp_reg, mp_next;
    logic [MUL_BITS-1:0] q_reg, q_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    alu_op_t             op_reg, op_next;
    logic                neg_reg, neg_next;
    logic                busy_reg, busy_next;
    logic                top_step;

    assign top_step = (cnt_reg == CNT_W'(MUL_BITS - 1));

    // the one shared adder
    always_comb
    begin
        add_a   = acc_reg;
        add_b   = mc_reg;
        add_sub = 1'b1;
        if (cmd.go)
        begin
            add_a = '0;
            add_b = acc_reg;
        end
        else if (op_reg == ALU_MUL)
        begin
            add_sub = neg_reg ^ top_step;
        end
        sum = add_a + (add_sub ? ~add_b : add_b) + ACC_BITS'(add_sub);
    end

    always_comb
    begin
        acc_next  = acc_reg;
        mc_next   = mc_reg;
        mp_next   = mp_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        op_next   = op_reg;
        neg_next  = neg_reg;
        busy_next = busy_reg;
        if (cmd.go)
        begin
            unique case (cmd.op)
                ALU_CLR: acc_next = '0;
                ALU_ABS:
                begin
                    if (acc_reg[ACC_BITS-1])
                    begin
                        acc_next = sum;
                    end
                end
                ALU_MUL:
                begin
                    mc_next   = ACC_BITS'(mcand);
                    mp_next   = MUL_BITS'(mplier);
                    cnt_next  = '0;
                    op_next   = ALU_MUL;
                    neg_next  = cmd.neg;
                    busy_next = 1'b1;
                end
                ALU_DIV:
                begin
                    mc_next   = ACC_BITS'(mcand);
                    q_next    = '0;
                    cnt_next  = '0;
                    op_next   = ALU_DIV;
                    busy_next = 1'b1;
                end
                default: acc_next = acc_reg;
            endcase
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
            if (top_step)
            begin
                busy_next = 1'b0;
            end
            if (op_reg == ALU_MUL)
            begin
                if (mp_reg[0])
                begin
                    acc_next = sum;
                end
                mc_next = mc_reg << 1;
                mp_next = mp_reg >> 1;
            end
            else
            begin
                if (!sum[ACC_BITS-1])
                begin
                    acc_next = sum;
                end
                q_next  = {q_reg[MUL_BITS-2:0], ~sum[ACC_BITS-1]};
                mc_next = mc_reg >> 1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            op_reg   <= ALU_CLR;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            op_reg   <= op_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        mc_reg  <= mc_next;
        mp_reg  <= mp_next;
        q_reg   <= q_next;
        neg_reg <= neg_next;
    end

    assign busy = busy_reg;
    assign acc  = acc_reg;
    assign quot = q_reg;

endmodule

@@ src/polygon_window_clipper.sv @@
// loading: one vertex per cycle, the final vertex starts clipping
// clipping: a pass per edge on one shared add/shift unit; each pass tests the last vertex,
//   then per vertex: inside test, intersection if the edge is crossed, write if kept
// results: list buffer vertices, each held until taken; next polygon taken after the last
// reset: control, counts and corners cleared; list buffers are not cleared
module polygon_window_clipper
    import pwc_pkg::*;
#(
    parameter int MAX_VERTS = MAX_VERTS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [COORD_BITS-1:0]   cfg_data,
    input  logic                    vert_valid,
    output logic                    vert_stall,
    input  vert_in_t                vert_data,
    output logic                    res_valid,
    input  logic                    res_stall,
    output clip_out_t               res_data
);

    localparam int CNT_BITS = $clog2(MAX_VERTS + 1);

    state_t                      state_reg, state_next;
    phase_t                      phase_reg, phase_next;
    logic [CNT_BITS-1:0]         cnt_reg, cnt_next;
    logic                        drop_reg, drop_next;
    logic                        ovf_reg, ovf_next;
    logic [LIST_CW-1:0]          n_reg, n_next;
    logic [LIST_CW-1:0]          m_reg, m_next;
    logic [LIST_CW-1:0]          j_reg, j_next;
    logic [EDGE_BITS-1:0]        edge_reg, edge_next;
    logic                        src_reg, src_next;
    logic [UPC_BITS-1:0]         upc_reg, upc_next;
    vertex_t                     c0_reg, c1_reg, c2_reg, c3_reg;
    vertex_t                     p_reg, p_next, s_reg, s_next, x_reg, x_next;
    logic                        pin_reg, pin_next, sin_reg, sin_next;
    logic signed [L_BITS-1:0]    l1_reg, l1_next, l2_reg, l2_next;
    logic [L_BITS-1:0]           dabs_reg, dabs_next;
    logic                        dneg_reg, dneg_next, nneg_reg, nneg_next;
    clip_out_t                   out_reg, out_next;
    logic                        outv_reg, outv_next;

    vertex_t                     a_v, b_v, rdata, wdata;
    logic                        we;
    logic [LIST_AW:0]            waddr, raddr;
    uop_t                        cur_uop;
    alu_cmd_t                    alu_cmd;
    logic signed [ACC_BITS-1:0]  mcand, acc_val;
    logic signed [MUL_BITS-1:0]  mplier;
    logic [MUL_BITS-1:0]         quot;
    logic                        alu_busy, acc_zero, prog_end, room, vert_acc, last_j;
    logic signed [MUL_BITS-1:0]  d_pxa, d_pya, d_bya, d_bxa, d_dx1, d_dy1, d_dx2, d_dy2;
    coord_t                      q_signed;

    always_comb
    begin
        case (edge_reg)
            2'd0:    begin a_v = c0_reg; b_v = c1_reg; end
            2'd1:    begin a_v = c1_reg; b_v = c2_reg; end
            2'd2:    begin a_v = c2_reg; b_v = c3_reg; end
            default: begin a_v = c3_reg; b_v = c0_reg; end
        endcase
    end

    assign d_pxa = MUL_BITS'(p_reg.x) - MUL_BITS'(a_v.x);
    assign d_pya = MUL_BITS'(p_reg.y) - MUL_BITS'(a_v.y);
    assign d_bya = MUL_BITS'(b_v.y) - MUL_BITS'(a_v.y);
    assign d_bxa = MUL_BITS'(b_v.x) - MUL_BITS'(a_v.x);
    assign d_dx1 = MUL_BITS'(a_v.x) - MUL_BITS'(b_v.x);
    assign d_dy1 = MUL_BITS'(a_v.y) - MUL_BITS'(b_v.y);
    assign d_dx2 = MUL_BITS'(s_reg.x) - MUL_BITS'(p_reg.x);
    assign d_dy2 = MUL_BITS'(s_reg.y) - MUL_BITS'(p_reg.y);

    assign cur_uop  = uop_at(upc_reg);
    assign alu_cmd  = '{go: (state_reg == S_ISSUE), op: cur_uop.op, neg: cur_uop.neg};
    assign acc_zero = (acc_val == '0);
    assign prog_end = cur_uop.last || (cur_uop.act == ACT_DEN && acc_zero);
    assign room     = (m_reg < LIST_CW'(LIST_DEPTH));
    assign vert_acc = vert_valid && !vert_stall;
    assign last_j   = (j_reg + LIST_CW'(1) == n_reg);
    assign q_signed = nneg_reg ? COORD_BITS'(-quot) : COORD_BITS'(quot);

    always_comb
    begin
        case (cur_uop.mc)
            M_PXA:   mcand = ACC_BITS'(d_pxa);
            M_PYA:   mcand = ACC_BITS'(d_pya);
            M_AX:    mcand = ACC_BITS'(a_v.x);
            M_AY:    mcand = ACC_BITS'(a_v.y);
            M_SX:    mcand = ACC_BITS'(s_reg.x);
            M_SY:    mcand = ACC_BITS'(s_reg.y);
            M_DX1:   mcand = ACC_BITS'(d_dx1);
            M_DY1:   mcand = ACC_BITS'(d_dy1);
            M_L1:    mcand = ACC_BITS'(l1_reg);
            M_L2:    mcand = ACC_BITS'(l2_reg);
            M_DSH:   mcand = {{DSH_PAD{1'b0}}, dabs_reg, {COORD_BITS{1'b0}}};
            default: mcand = '0;
        endcase
        case (cur_uop.mp)
            R_BYA:   mplier = d_bya;
            R_BXA:   mplier = d_bxa;
            R_BY:    mplier = MUL_BITS'(b_v.y);
            R_BX:    mplier = MUL_BITS'(b_v.x);
            R_PY:    mplier = MUL_BITS'(p_reg.y);
            R_PX:    mplier = MUL_BITS'(p_reg.x);
            R_DY2:   mplier = d_dy2;
            R_DX2:   mplier = d_dx2;
            R_DX1:   mplier = d_dx1;
            R_DY1:   mplier = d_dy1;
            default: mplier = '0;
        endcase
    end

    pwc_alu u_alu (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (alu_cmd),
        .mcand  (mcand),
        .mplier (mplier),
        .busy   (alu_busy),
        .acc    (acc_val),
        .quot   (quot)
    );

    pwc_vbuf u_vbuf (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_LOAD:
            begin
                if (vert_valid && vert_data.final_vertex)
                begin
                    state_next = S_PASS_INIT;
                end
            end
            S_PASS_INIT: state_next = (n_reg == '0) ? S_PASS_END : S_RD_WAIT;
            S_RD_WAIT:   state_next = S_ISSUE;
            S_ISSUE:     state_next = S_WAIT;
            S_WAIT:
            begin
                if (!alu_busy)
                begin
                    state_next = prog_end ? S_AFTER : S_ISSUE;
                end
            end
            S_AFTER:
            begin
                case (phase_reg)
                    PH_S: state_next = S_RD_WAIT;
                    PH_P:
                    begin
                        if (pin_reg != sin_reg)
                        begin
                            state_next = S_ISSUE;
                        end
                        else
                        begin
                            state_next = pin_reg ? S_WR_PT : S_ADV;
                        end
                    end
                    default: state_next = S_WR_ISECT;
                endcase
            end
            S_WR_ISECT: state_next = pin_reg ? S_WR_PT : S_ADV;
            S_WR_PT:    state_next = S_ADV;
            S_ADV:      state_next = last_j ? S_PASS_END : S_RD_WAIT;
            S_PASS_END:
            begin
                if (edge_reg == EDGE_BITS'(NUM_EDGES - 1))
                begin
                    state_next = (m_reg == '0) ? S_EMIT_HOLD : S_EMIT_RD;
                end
                else
                begin
                    state_next = S_PASS_INIT;
                end
            end
            S_EMIT_RD: state_next = S_EMIT_LD;
            S_EMIT_LD: state_next = S_EMIT_HOLD;
            S_EMIT_HOLD:
            begin
                if (!res_stall)
                begin
                    state_next = out_reg.end_of_list ? S_LOAD : S_EMIT_RD;
                end
            end
            default: state_next = S_LOAD;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        drop_next  = drop_reg;
        ovf_next   = ovf_reg;
        n_next     = n_reg;
        m_next     = m_reg;
        j_next     = j_reg;
        edge_next  = edge_reg;
        src_next   = src_reg;
        upc_next   = upc_reg;
        p_next     = p_reg;
        s_next     = s_reg;
        x_next     = x_reg;
        pin_next   = pin_reg;
        sin_next   = sin_reg;
        l1_next    = l1_reg;
        l2_next    = l2_reg;
        dabs_next  = dabs_reg;
        dneg_next  = dneg_reg;
        nneg_next  = nneg_reg;
        out_next   = out_reg;
        outv_next  = outv_reg;
        we         = 1'b0;
        waddr      = {~src_reg, m_reg[LIST_AW-1:0]};
        wdata      = p_reg;
        raddr      = {src_reg, j_reg[LIST_AW-1:0]};
        vert_stall = (state_reg != S_LOAD);

        unique case (state_reg)
            S_LOAD:
            begin
                if (vert_acc)
                begin
                    if (cnt_reg < CNT_BITS'(MAX_VERTS))
                    begin
                        we       = 1'b1;
                        waddr    = {src_reg, LIST_AW'(cnt_reg)};
                        wdata    = '{x: vert_data.vert_x, y: vert_data.vert_y};
                        cnt_next = cnt_reg + CNT_BITS'(1);
                    end
                    else
                    begin
                        drop_next = 1'b1;
                    end
                    n_next    = LIST_CW'(cnt_next);
                    ovf_next  = drop_next;
                    edge_next = '0;
                end
            end
            S_PASS_INIT:
            begin
                m_next     = '0;
                j_next     = '0;
                phase_next = PH_S;
                raddr      = {src_reg, LIST_AW'(n_reg - LIST_CW'(1))};
            end
            S_RD_WAIT:
            begin
                p_next   = rdata;
                upc_next = UPC_INSIDE;
            end
            S_WAIT:
            begin
                if (!alu_busy)
                begin
                    case (cur_uop.act)
                        ACT_INSIDE: pin_next  = !acc_val[ACC_BITS-1] && !acc_zero;
                        ACT_L1:     l1_next   = L_BITS'(acc_val);
                        ACT_L2:     l2_next   = L_BITS'(acc_val);
                        ACT_DEN:
                        begin
                            dneg_next = acc_val[ACC_BITS-1];
                            if (acc_zero)
                            begin
                                x_next = p_reg;
                            end
                        end
                        ACT_DABS:   dabs_next = L_BITS'(acc_val);
                        ACT_NSIGN:  nneg_next = acc_val[ACC_BITS-1] ^ dneg_reg;
                        ACT_RX:     x_next.x  = q_signed;
                        ACT_RY:     x_next.y  = q_signed;
                        default:    x_next    = x_reg;
                    endcase
                    if (!prog_end)
                    begin
                        upc_next = upc_reg + UPC_BITS'(1);
                    end
                end
            end
            S_AFTER:
            begin
                case (phase_reg)
                    PH_S:
                    begin
                        s_next     = p_reg;
                        sin_next   = pin_reg;
                        j_next     = '0;
                        phase_next = PH_P;
                        raddr      = {src_reg, {LIST_AW{1'b0}}};
                    end
                    PH_P:
                    begin
                        if (pin_reg != sin_reg)
                        begin
                            phase_next = PH_X;
                            upc_next   = UPC_ISECT;
                        end
                    end
                    default: phase_next = PH_P;
                endcase
            end
            S_WR_ISECT:
            begin
                wdata = x_reg;
                if (room)
                begin
                    we     = 1'b1;
                    m_next = m_reg + LIST_CW'(1);
                end
                else
                begin
                    ovf_next = 1'b1;
                end
            end
            S_WR_PT:
            begin
                if (room)
                begin
                    we     = 1'b1;
                    m_next = m_reg + LIST_CW'(1);
                end
                else
                begin
                    ovf_next = 1'b1;
                end
            end
            S_ADV:
            begin
                s_next     = p_reg;
                sin_next   = pin_reg;
                j_next     = j_reg + LIST_CW'(1);
                phase_next = PH_P;
                raddr      = {src_reg, LIST_AW'(j_reg + LIST_CW'(1))};
            end
            S_PASS_END:
            begin
                n_next    = m_reg;
                src_next  = ~src_reg;
                edge_next = edge_reg + EDGE_BITS'(1);
                j_next    = '0;
                if (edge_reg == EDGE_BITS'(NUM_EDGES - 1) && m_reg == '0)
                begin
                    out_next  = '{out_x: '0, out_y: '0, end_of_list: 1'b1,
                                  empty_result: 1'b1, overflowed: ovf_reg};
                    outv_next = 1'b1;
                end
            end
            S_EMIT_LD:
            begin
                out_next  = '{out_x: rdata.x, out_y: rdata.y, end_of_list: last_j,
                              empty_result: 1'b0, overflowed: ovf_reg};
                outv_next = 1'b1;
            end
            S_EMIT_HOLD:
            begin
                if (!res_stall)
                begin
                    outv_next = 1'b0;
                    j_next    = j_reg + LIST_CW'(1);
                    if (out_reg.end_of_list)
                    begin
                        cnt_next  = '0;
                        drop_next = 1'b0;
                    end
                end
            end
            default: we = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            phase_reg <= PH_S;
            cnt_reg   <= '0;
            drop_reg  <= 1'b0;
            ovf_reg   <= 1'b0;
            n_reg     <= '0;
            m_reg     <= '0;
            j_reg     <= '0;
            edge_reg  <= '0;
            src_reg   <= 1'b0;
            upc_reg   <= '0;
            outv_reg  <= 1'b0;
            c0_reg    <= '0;
            c1_reg    <= '0;
            c2_reg    <= '0;
            c3_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            drop_reg  <= drop_next;
            ovf_reg   <= ovf_next;
            n_reg     <= n_next;
            m_reg     <= m_next;
            j_reg     <= j_next;
            edge_reg  <= edge_next;
            src_reg   <= src_next;
            upc_reg   <= upc_next;
            outv_reg  <= outv_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_CORNER0_X: c0_reg.x <= cfg_data;
                    CFG_CORNER0_Y: c0_reg.y <= cfg_data;
                    CFG_CORNER1_X: c1_reg.x <= cfg_data;
                    CFG_CORNER1_Y: c1_reg.y <= cfg_data;
                    CFG_CORNER2_X: c2_reg.x <= cfg_data;
                    CFG_CORNER2_Y: c2_reg.y <= cfg_data;
                    CFG_CORNER3_X: c3_reg.x <= cfg_data;
                    CFG_CORNER3_Y: c3_reg.y <= cfg_data;
                    default:       c0_reg   <= c0_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg    <= p_next;
        s_reg    <= s_next;
        x_reg    <= x_next;
        pin_reg  <= pin_next;
        sin_reg  <= sin_next;
        l1_reg   <= l1_next;
        l2_reg   <= l2_next;
        dabs_reg <= dabs_next;
        dneg_reg <= dneg_next;
        nneg_reg <= nneg_next;
        out_reg  <= out_next;
    end

    assign res_valid = outv_reg;
    assign res_data  = out_reg;

    a_no_load_while_emit: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> vert_stall)
        else $error("input taken while a result is pending");

    a_alu_idle_on_issue: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ISSUE) |-> !alu_busy)
        else $error("shared unit started while busy");

    a_ready_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_stall && res_data.end_of_list) |=> !vert_stall)
        else $error("not ready for a new polygon after the last result");

    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_data.empty_result) |->
            (res_data.end_of_list && res_data.out_x == '0 && res_data.out_y == '0))
        else $error("malformed empty result");

endmodule
